[sv/deq_pkg.sv]
// Shared types and codes for the double-ended queue core.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DUMP_RD,
        S_DUMP_WR
    } state_t;

    typedef enum logic {
        OSEL_ZERO,
        OSEL_MEM
    } out_sel_t;

    typedef struct packed {
        logic                capture;
        logic                push_front;
        logic                push_back;
        logic                pop_front;
        logic                pop_back;
        logic                dump_start;
        logic                dump_read;
        logic                dump_next;
        logic                load_out;
        out_sel_t            out_sel;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             out_free;
        logic             dump_last;
    } dp_status_t;

endpackage

`default_nettype wire

[sv/deq_ctrl.sv]
// Command sequencer for the double-ended queue core.
// Uses deq_pkg for state, command and status types.
`default_nettype none

module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire deq_pkg::dp_status_t stat,
    output deq_pkg::ctrl_cmd_t     cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC:
            begin
                if (stat.out_free)
                begin
                    case (stat.cmd)
                        deq_pkg::CMD_POP_FRONT,
                        deq_pkg::CMD_POP_BACK:
                        begin
                            state_next = stat.empty ? deq_pkg::S_IDLE : deq_pkg::S_POP;
                        end
                        deq_pkg::CMD_DUMP:
                        begin
                            state_next = stat.empty ? deq_pkg::S_IDLE : deq_pkg::S_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = deq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            deq_pkg::S_POP:
            begin
                if (stat.out_free)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            deq_pkg::S_DUMP_RD:
            begin
                state_next = deq_pkg::S_DUMP_WR;
            end
            deq_pkg::S_DUMP_WR:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.dump_last ? deq_pkg::S_IDLE : deq_pkg::S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            deq_pkg::S_EXEC:
            begin
                if (stat.out_free)
                begin
                    case (stat.cmd)
                        deq_pkg::CMD_PUSH_FRONT,
                        deq_pkg::CMD_PUSH_BACK:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.out_status = deq_pkg::ST_OK;
                                cmd.push_front = (stat.cmd == deq_pkg::CMD_PUSH_FRONT);
                                cmd.push_back  = (stat.cmd == deq_pkg::CMD_PUSH_BACK);
                            end
                        end
                        deq_pkg::CMD_POP_FRONT,
                        deq_pkg::CMD_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_status = deq_pkg::ST_EMPTY;
                                cmd.out_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_front = (stat.cmd == deq_pkg::CMD_POP_FRONT);
                                cmd.pop_back  = (stat.cmd == deq_pkg::CMD_POP_BACK);
                            end
                        end
                        deq_pkg::CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_status = deq_pkg::ST_EMPTY;
                                cmd.out_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.load_out   = 1'b1;
                            cmd.out_status = deq_pkg::ST_OK;
                            cmd.out_last   = 1'b1;
                        end
                    endcase
                end
            end
            deq_pkg::S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = deq_pkg::OSEL_MEM;
                    cmd.out_status = deq_pkg::ST_OK;
                    cmd.out_last   = 1'b1;
                end
            end
            deq_pkg::S_DUMP_RD:
            begin
                cmd.dump_read = 1'b1;
            end
            deq_pkg::S_DUMP_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = deq_pkg::OSEL_MEM;
                    cmd.out_status = deq_pkg::ST_OK;
                    cmd.out_last   = stat.dump_last;
                    cmd.dump_next  = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/deq_datapath.sv]
// Element store, index registers, dump offset and result register of the deque.
// Uses deq_pkg for command and status structs and field widths.
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [deq_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [deq_pkg::DATA_W-1:0]    in_value,
    input  wire deq_pkg::ctrl_cmd_t            cmd,
    output deq_pkg::dp_status_t                stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [deq_pkg::DATA_W-1:0]         out_value,
    output logic [deq_pkg::STATUS_W-1:0]       out_status,
    output logic                               out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [deq_pkg::DATA_W-1:0]   mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0]   rdata_reg;
    logic [deq_pkg::CMD_W-1:0]    cmd_reg;
    logic [deq_pkg::DATA_W-1:0]   value_reg;
    logic [AW-1:0]                front_reg;
    logic [AW-1:0]                front_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [AW-1:0]                offset_reg;
    logic                         out_valid_reg;
    logic [deq_pkg::DATA_W-1:0]   out_value_reg;
    logic [deq_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;
    logic [AW-1:0]                front_dec;
    logic [AW-1:0]                back_slot;
    logic [AW-1:0]                last_slot;
    logic [AW-1:0]                dump_slot;
    logic [AW-1:0]                waddr;
    logic                         we;
    logic [AW-1:0]                raddr;
    logic                         re;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW + 1)'(DEPTH))
        begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign back_slot = wrap_add(front_reg, count_reg[AW-1:0]);
    assign last_slot = wrap_add(front_reg, count_next[AW-1:0]);
    assign dump_slot = wrap_add(front_reg, offset_reg);

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.dump_last = ((CW'(offset_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            front_next = wrap_add(front_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_back)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign we    = cmd.push_front || cmd.push_back;
    assign waddr = cmd.push_front ? front_dec : back_slot;
    assign re    = cmd.pop_front || cmd.pop_back || cmd.dump_read;
    assign raddr = cmd.pop_front ? front_reg : (cmd.pop_back ? last_slot : dump_slot);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
        end
        if (cmd.load_out)
        begin
            out_value_reg  <= (cmd.out_sel == deq_pkg::OSEL_MEM) ? rdata_reg : '0;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.dump_start)
            begin
                offset_reg <= '0;
            end
            else if (cmd.dump_next)
            begin
                offset_reg <= offset_reg + AW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

[sv/double_ended_queue_core.sv]
// Sequence: an accepted command is registered; a push, an empty pop, an empty dump or an
// ignored code then loads its item into the output register. A pop that returns a value
// first reads the store through its registered read port; a dump reads and outputs each
// element in turn. Loads wait on a stalled output; a new command waits for the last to end.
// Reset: front index, count, dump offset, sequencer and output valid clear; the store is not cleared.
// Top level of the double-ended queue; depends on deq_pkg, deq_ctrl and deq_datapath.
`default_nettype none

module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value_out
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast
);

    deq_pkg::ctrl_cmd_t  ctrl_cmd;
    deq_pkg::dp_status_t dp_stat;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_cmd     (s_axis_tuser),
        .in_value   (s_axis_tdata),
        .cmd        (ctrl_cmd),
        .stat       (dp_stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (m_axis_tdata),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

[sv/deq_checker.sv]
// Port-level checks for the double-ended queue core, bound to its top level.
// Uses deq_pkg status codes.
`default_nettype none

module deq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while one is in progress");

    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_EMPTY || m_axis_tuser == deq_pkg::ST_FULL)
            |-> m_axis_tlast && (m_axis_tdata == 32'd0))
        else $error("empty or full report not a single zero item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
